// ===== hdl/dmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and codes for the max-flow core.
// ----------------------------------------------------------------------------
package dmf_pkg;

  localparam int FLOW_W = 48;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAME = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_SINK       = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD1, S_LD2, S_CHECK,
    S_BINIT, S_BSEED, S_BPOP, S_BV, S_BE0, S_BEDGE, S_BH, S_BL, S_BDONE, S_BCHK,
    S_AINIT, S_ATOP, S_AC, S_AH, S_AL, S_ARET1, S_ARET2,
    S_M0, S_M1, S_M2, S_U0, S_U1, S_U2, S_U3, S_EMIT
  } state_t;

endpackage

// ===== hdl/dmf_edge_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_edge_if
// Edge word channel: tail, head, capacity and last marker.
// ----------------------------------------------------------------------------
interface dmf_edge_if;
  logic        valid;
  logic        ready;
  logic [7:0]  from_node;
  logic [7:0]  to_node;
  logic [31:0] capacity;
  logic        last_edge;

  modport source (output valid, from_node, to_node, capacity, last_edge, input ready);
  modport sink   (input valid, from_node, to_node, capacity, last_edge, output ready);
endinterface

// ===== hdl/dmf_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_result_if
// Result word channel: total flow and status.
// ----------------------------------------------------------------------------
interface dmf_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] total_flow;
  logic [1:0]  status;

  modport source (output valid, total_flow, status, input ready);
  modport sink   (input valid, total_flow, status, output ready);
endinterface

// ===== hdl/dmf_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface dmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/dmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module dmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/dinic_max_flow_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dinic_max_flow_core
// Dinic max flow over an edge list held in block RAM, one result per graph.
// ----------------------------------------------------------------------------
// Edge intake: a stored edge passes through S_LD1 and S_LD2 before the next
//   edge word is taken; a dropped edge is discarded in S_IDLE. After the last
//   edge the solve runs level passes that scan edges, walk steps, a pass over
//   the path edges to take the minimum and a pass to push flow; RAM reads are registered.
// Edge intake is bounded by the node list RAM port, which both load states write.
// Reset: control clears at once, then a sweep empties the node list; the same
//   sweep runs after each result. No edge is taken meanwhile.
module dinic_max_flow_core #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024,
  parameter int CAP_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  dmf_edge_if.sink     edges,
  dmf_result_if.source result,
  dmf_cfg_if.sink      cfg
);
  import dmf_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCW = ($clog2(MAX_NODES + 1) > 9) ? $clog2(MAX_NODES + 1) : 9;
  localparam int LW  = NW + 1;
  localparam int ES  = 2 * MAX_EDGES;
  localparam int EW  = $clog2(ES);
  localparam int EPW = $clog2(ES + 1);
  localparam logic [EPW-1:0] ENONE = EPW'(ES);
  localparam logic [LW-1:0]  UNR   = '1;
  localparam logic [47:0] CAP_MAX  = (48'(1) << CAP_BITS) - 48'(1);
  localparam logic [47:0] FLOW_MAX = '1;

  state_t state, state_next;

  logic [8:0] node_count;
  logic [7:0] source_node, sink_node;

  logic [NCW-1:0]      eff_n, i_cnt;
  logic [NW:0]         qhead, qtail, depth;
  logic [NW-1:0]       v, h, ld_from, ld_to;
  logic [EPW-1:0]      e, nx, ecnt;
  logic [LW-1:0]       lv;
  logic [CAP_BITS-1:0] dmin, ld_cap, cap_sat;
  logic [47:0]         flow_sum;
  logic                drop, zero_flow, ld_last;
  logic [1:0]          status_r;
  logic [47:0]         cap48;
  logic                edge_ok;
  logic [NW-1:0]       src, snk;

  // RAM ports
  logic                first_we, lvl_we, cur_we, q_we, path_we, edge_we, res_we;
  logic [NW-1:0]       first_wa, first_ra, lvl_wa, lvl_ra, cur_wa, cur_ra;
  logic [NW-1:0]       q_wa, q_ra, path_wa, path_ra;
  logic [EW-1:0]       edge_wa, edge_ra, res_wa, res_ra, head_ra;
  logic [EPW-1:0]      first_wd, first_rd, cur_wd, cur_rd, next_wd, next_rd;
  logic [LW-1:0]       lvl_wd, lvl_rd;
  logic [NW-1:0]       q_wd, q_rd, head_wd, head_rd;
  logic [EW-1:0]       path_wd, path_rd;
  logic [CAP_BITS-1:0] res_wd, res_rd, edge_res_wd;

  logic [CAP_BITS-1:0] dmin_new;
  logic [48:0]         flow_add;

  assign eff_n = (NCW'(node_count) < NCW'(MAX_NODES)) ? NCW'(node_count) : NCW'(MAX_NODES);
  assign src   = NW'(source_node);
  assign snk   = NW'(sink_node);
  assign cap48 = 48'(edges.capacity);
  assign cap_sat = CAP_BITS'((cap48 > CAP_MAX) ? CAP_MAX : cap48);
  assign edge_ok = (NCW'(edges.from_node) < eff_n) && (NCW'(edges.to_node) < eff_n)
                   && ((EPW + 1)'(ecnt) + (EPW + 1)'(2) <= (EPW + 1)'(ES));
  assign dmin_new = (res_rd < dmin) ? res_rd : dmin;
  assign flow_add = {1'b0, flow_sum} + 49'(dmin_new);

  assign edges.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 9'd256;
      source_node <= 8'd0;
      sink_node   <= 8'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NODE_COUNT: node_count  <= cfg.data;
        CFG_SOURCE:     source_node <= cfg.data[7:0];
        CFG_SINK:       sink_node   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (i_cnt == NCW'(MAX_NODES - 1)) state_next = S_IDLE;
      S_IDLE:  if (edges.valid) begin
        if (edge_ok) state_next = S_LD1;
        else if (edges.last_edge) state_next = S_CHECK;
      end
      S_LD1:   state_next = S_LD2;
      S_LD2:   state_next = ld_last ? S_CHECK : S_IDLE;
      S_CHECK: begin
        if (source_node == sink_node) state_next = S_EMIT;
        else if (NCW'(source_node) < eff_n && NCW'(sink_node) < eff_n) state_next = S_BINIT;
        else state_next = S_EMIT;
      end
      S_BINIT: if (i_cnt == eff_n - NCW'(1)) state_next = S_BSEED;
      S_BSEED: state_next = S_BPOP;
      S_BPOP:  state_next = (qhead < qtail) ? S_BV : S_BDONE;
      S_BV:    state_next = S_BE0;
      S_BE0:   state_next = S_BEDGE;
      S_BEDGE: state_next = (e < ENONE) ? S_BH : S_BPOP;
      S_BH: begin
        if (NCW'(head_rd) < eff_n && |res_rd && qtail < (NW + 1)'(MAX_NODES))
          state_next = S_BL;
        else state_next = S_BEDGE;
      end
      S_BL:    state_next = S_BEDGE;
      S_BDONE: state_next = S_BCHK;
      S_BCHK:  state_next = (lvl_rd == UNR) ? S_EMIT : S_AINIT;
      S_AINIT: if (i_cnt == eff_n) state_next = S_ATOP;
      S_ATOP:  state_next = (v == snk) ? S_M0 : S_AC;
      S_AC: begin
        if (cur_rd < ENONE) state_next = S_AH;
        else if (depth == '0) state_next = S_BINIT;
        else state_next = S_ARET1;
      end
      S_AH: begin
        if (NCW'(head_rd) < eff_n && |res_rd && depth < (NW + 1)'(MAX_NODES))
          state_next = S_AL;
        else state_next = S_ATOP;
      end
      S_AL:    state_next = S_ATOP;
      S_ARET1: state_next = S_ARET2;
      S_ARET2: state_next = S_ATOP;
      S_M0:    state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = (i_cnt == NCW'(depth) - NCW'(1)) ? S_U0 : S_M0;
      S_U0:    state_next = S_U1;
      S_U1:    state_next = S_U2;
      S_U2:    state_next = S_U3;
      S_U3:    state_next = (i_cnt == NCW'(depth) - NCW'(1)) ? S_ATOP : S_U0;
      S_EMIT:  if (!result.valid || result.ready) state_next = S_CLR;
      default: state_next = S_CLR;
    endcase
  end

  // RAM control
  always_comb begin
    first_we = 1'b0; first_wa = '0; first_wd = '0; first_ra = '0;
    lvl_we = 1'b0;   lvl_wa = '0;   lvl_wd = '0;   lvl_ra = '0;
    cur_we = 1'b0;   cur_wa = '0;   cur_wd = '0;   cur_ra = '0;
    q_we = 1'b0;     q_wa = '0;     q_wd = '0;     q_ra = '0;
    path_we = 1'b0;  path_wa = '0;  path_wd = '0;  path_ra = '0;
    edge_we = 1'b0;  edge_wa = '0;  head_wd = '0;  next_wd = '0; edge_res_wd = '0;
    edge_ra = '0;    head_ra = '0;
    res_we = 1'b0;   res_wa = '0;   res_wd = '0;   res_ra = '0;
    case (state)
      S_CLR: begin
        first_we = 1'b1; first_wa = NW'(i_cnt); first_wd = ENONE;
      end
      S_IDLE: first_ra = NW'(edges.from_node);
      S_LD1: begin
        edge_we = 1'b1; edge_wa = EW'(ecnt);
        head_wd = ld_to; edge_res_wd = ld_cap; next_wd = first_rd;
        first_we = 1'b1; first_wa = ld_from; first_wd = ecnt;
        first_ra = ld_to;
      end
      S_LD2: begin
        // self loop: the tail list head is the forward slot just linked
        edge_we = 1'b1; edge_wa = EW'(ecnt) | EW'(1);
        head_wd = ld_from; edge_res_wd = '0;
        next_wd = (ld_to == ld_from) ? ecnt : first_rd;
        first_we = 1'b1; first_wa = ld_to; first_wd = ecnt + EPW'(1);
      end
      S_BINIT: begin
        lvl_we = 1'b1; lvl_wa = NW'(i_cnt); lvl_wd = UNR;
      end
      S_BSEED: begin
        lvl_we = 1'b1; lvl_wa = src; lvl_wd = '0;
        q_we = 1'b1; q_wa = '0; q_wd = src;
      end
      S_BPOP:  q_ra = NW'(qhead);
      S_BV: begin
        first_ra = q_rd; lvl_ra = q_rd;
      end
      S_BEDGE: begin
        edge_ra = EW'(e); res_ra = EW'(e);
      end
      S_BH:    lvl_ra = head_rd;
      S_BL: if (lvl_rd == UNR) begin
        lvl_we = 1'b1; lvl_wa = h; lvl_wd = lv + LW'(1);
        q_we = 1'b1; q_wa = NW'(qtail); q_wd = h;
      end
      S_BDONE: lvl_ra = snk;
      S_AINIT: begin
        first_ra = NW'(i_cnt);
        if (i_cnt != '0) begin
          cur_we = 1'b1; cur_wa = NW'(i_cnt - NCW'(1)); cur_wd = first_rd;
        end
      end
      S_ATOP: begin
        cur_ra = v; lvl_ra = v;
      end
      S_AC: begin
        edge_ra = EW'(cur_rd); res_ra = EW'(cur_rd);
        path_ra = NW'(depth - (NW + 1)'(1));
      end
      S_AH: begin
        lvl_ra = head_rd;
        if (!(NCW'(head_rd) < eff_n && |res_rd && depth < (NW + 1)'(MAX_NODES))) begin
          cur_we = 1'b1; cur_wa = v; cur_wd = next_rd;
        end
      end
      S_AL: begin
        if (lvl_rd != UNR && lv < lvl_rd) begin
          path_we = 1'b1; path_wa = NW'(depth); path_wd = EW'(e);
        end else begin
          cur_we = 1'b1; cur_wa = v; cur_wd = nx;
        end
      end
      S_ARET1: begin
        // head of the paired reverse edge is the node we back up to
        edge_ra = path_rd ^ EW'(1);
      end
      S_ARET2: begin
        cur_we = 1'b1; cur_wa = head_rd; cur_wd = next_rd;
      end
      S_M0:    path_ra = NW'(i_cnt);
      S_M1:    res_ra = path_rd;
      S_U0:    path_ra = NW'(i_cnt);
      S_U1:    res_ra = path_rd;
      S_U2: begin
        res_we = 1'b1; res_wa = EW'(e); res_wd = res_rd - dmin;
        res_ra = EW'(e) ^ EW'(1);
      end
      S_U3: begin
        res_we = 1'b1; res_wa = EW'(e) ^ EW'(1); res_wd = res_rd + dmin;
      end
      default: ;
    endcase
    if (edge_we) begin
      res_we = 1'b1; res_wa = edge_wa; res_wd = edge_res_wd;
    end
    head_ra = edge_ra;
  end

  // ARET1 reads next of the popped edge on the next RAM port while the head
  // RAM reads the paired reverse edge; both land in ARET2.
  logic [EW-1:0] next_ra;
  assign next_ra = (state == S_ARET1) ? path_rd : edge_ra;

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      i_cnt     <= '0;
      ecnt      <= '0;
      flow_sum  <= '0;
      drop      <= 1'b0;
      qhead     <= '0;
      qtail     <= '0;
      depth     <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && (!result.valid || result.ready)) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      case (state)
        S_CLR: begin
          i_cnt <= (state_next == S_IDLE) ? '0 : i_cnt + NCW'(1);
          ecnt <= '0; flow_sum <= '0; drop <= 1'b0;
        end
        S_IDLE: if (edges.valid) begin
          ld_from <= NW'(edges.from_node);
          ld_to   <= NW'(edges.to_node);
          ld_cap  <= cap_sat;
          ld_last <= edges.last_edge;
          if (!edge_ok) drop <= 1'b1;
        end
        S_LD2:   ecnt <= ecnt + EPW'(2);
        S_CHECK: begin
          i_cnt <= '0;
          zero_flow <= 1'b1;
          if (source_node == sink_node) status_r <= STATUS_SAME;
          else begin
            status_r <= drop ? STATUS_DROP : STATUS_OK;
            zero_flow <= !(NCW'(source_node) < eff_n && NCW'(sink_node) < eff_n);
          end
        end
        S_BINIT: i_cnt <= (state_next == S_BSEED) ? '0 : i_cnt + NCW'(1);
        S_BSEED: begin
          qhead <= '0; qtail <= (NW + 1)'(1);
        end
        S_BPOP:  if (qhead < qtail) qhead <= qhead + (NW + 1)'(1);
        S_BV:    v <= q_rd;
        S_BE0: begin
          e <= first_rd; lv <= lvl_rd;
        end
        S_BH: begin
          h <= head_rd; nx <= next_rd;
          if (state_next == S_BEDGE) e <= next_rd;
        end
        S_BL: begin
          if (lvl_rd == UNR) qtail <= qtail + (NW + 1)'(1);
          e <= nx;
        end
        S_BCHK: begin
          i_cnt <= '0;
          if (lvl_rd == UNR) zero_flow <= 1'b0;
        end
        S_AINIT: begin
          i_cnt <= i_cnt + NCW'(1);
          if (i_cnt == eff_n) begin
            v <= src; depth <= '0; i_cnt <= '0;
          end
        end
        S_ATOP: begin
          i_cnt <= '0;
          dmin  <= CAP_MAX[CAP_BITS-1:0];
        end
        S_AC: begin
          lv <= lvl_rd; e <= cur_rd;
          if (!(cur_rd < ENONE) && depth != '0) depth <= depth - (NW + 1)'(1);
          i_cnt <= '0;
        end
        S_AH: begin
          h <= head_rd; nx <= next_rd;
        end
        S_AL: if (lvl_rd != UNR && lv < lvl_rd) begin
          depth <= depth + (NW + 1)'(1);
          v <= h;
        end
        S_ARET1: ;
        S_ARET2: v <= head_rd;
        S_M2: begin
          dmin <= dmin_new;
          if (state_next == S_U0) begin
            i_cnt <= '0;
            flow_sum <= flow_add[48] ? FLOW_MAX : flow_add[47:0];
          end else begin
            i_cnt <= i_cnt + NCW'(1);
          end
        end
        S_U1:    e <= EPW'(path_rd);
        S_U3: begin
          i_cnt <= i_cnt + NCW'(1);
          if (state_next == S_ATOP) begin
            depth <= '0; v <= src;
          end
        end
        S_EMIT: if (!result.valid || result.ready) begin
          result.total_flow <= zero_flow ? '0 : flow_sum;
          result.status     <= status_r;
          i_cnt <= '0;
        end
        default: ;
      endcase
    end
  end

  dmf_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_first (
    .clk(clk), .we(first_we), .waddr(first_wa), .wdata(first_wd),
    .raddr(first_ra), .rdata(first_rd));
  dmf_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_level (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .raddr(lvl_ra), .rdata(lvl_rd));
  dmf_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_cursor (
    .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
    .raddr(cur_ra), .rdata(cur_rd));
  dmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd));
  dmf_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_path (
    .clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
    .raddr(path_ra), .rdata(path_rd));
  dmf_ram #(.WIDTH(NW), .DEPTH(ES)) u_head (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd));
  dmf_ram #(.WIDTH(EPW), .DEPTH(ES)) u_next (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_rd));
  dmf_ram #(.WIDTH(CAP_BITS), .DEPTH(ES)) u_resid (
    .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd),
    .raddr(res_ra), .rdata(res_rd));

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.status != 2'd3) else $error("bad status code");
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    qhead <= qtail) else $error("queue head passed tail");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= (NW + 1)'(MAX_NODES)) else $error("path stack overflow");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    ecnt <= ENONE) else $error("edge count past memory");
endmodule
